### hw/rtl/orsb_pkg.sv
// Shared types, constants and helper functions of the overwrite ring snapshot buffer.
`timescale 1ns / 1ps
`default_nettype none

package orsb_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SIZE_W  = 7;
    localparam int WORD_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CMP_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(64);
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SNAP = 1'b1;
    localparam logic STATUS_WORD  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;
    localparam logic REG_SIZE_IN_USE = 1'b0;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              status;
        logic              last;
    } t_out;

    typedef enum logic {
        ST_IDLE,
        ST_SNAP
    } t_state;

    function automatic logic [CNT_W-1:0] ring_size(input logic [SIZE_W-1:0] s);
        logic [CMP_W-1:0] e;
        e = CMP_W'(s);
        if (e == '0) begin
            e = CMP_W'(1);
        end
        if (e > CMP_W'(DEPTH)) begin
            e = CMP_W'(DEPTH);
        end
        return CNT_W'(e);
    endfunction

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= size) ? '0 : IDX_W'(n);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/overwrite_ring_snapshot_buffer.sv
// Top level of the overwrite ring snapshot buffer: ring control, snapshot read-out, APB register.
//
// Input beats carry an op and a word. A push beat writes the word after the newest entry
// and overwrites the oldest entry once the ring holds size_in_use words; it gives no
// output beat. A snapshot beat reads the stored words oldest first from the slot memory,
// one output beat per cycle while the receiver is ready, the final one marked by last.
// The first word passes through the registered read of the slot memory and the output
// register; the input side stays busy until the last word is loaded into the output register.
// On an empty ring a single beat with empty status appears in the cycle after the request.
// Pushes are taken while a result waits at the output; a snapshot waits until the output
// register is free. A stalled receiver holds the read-out, and nothing is lost.
// The APB register size_in_use lies at byte address 0; a write empties the ring.
// After reset the ring is empty and size_in_use is 64. The slot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module overwrite_ring_snapshot_buffer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire orsb_pkg::t_in                   i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output orsb_pkg::t_out                       o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [orsb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [orsb_pkg::PDATA_W-1:0]    pwdata,
    output logic      [orsb_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    orsb_pkg::t_state                r_state, n_state;
    logic [orsb_pkg::CNT_W-1:0]      r_fill, n_fill;
    logic [orsb_pkg::IDX_W-1:0]      r_old, n_old;
    logic [orsb_pkg::IDX_W-1:0]      r_new, n_new;
    logic [orsb_pkg::SIZE_W-1:0]     r_size, n_size;
    logic [orsb_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [orsb_pkg::CNT_W-1:0]      r_left, n_left;
    logic                            r_out_valid, n_out_valid;
    orsb_pkg::t_out                  r_out, n_out;

    logic                            out_free;
    logic                            accept;
    logic                            cfg_wr;
    logic [orsb_pkg::CNT_W-1:0]      size;
    logic [orsb_pkg::IDX_W-1:0]      nxt_new;
    logic [orsb_pkg::IDX_W-1:0]      nxt_idx;
    logic                            out_load;
    logic                            ram_we;
    logic [orsb_pkg::IDX_W-1:0]      ram_waddr;
    logic                            ram_re;
    logic [orsb_pkg::IDX_W-1:0]      ram_raddr;
    logic [orsb_pkg::WORD_W-1:0]     ram_rdata;

    assign out_free = !r_out_valid || i_out_ready;
    assign size     = orsb_pkg::ring_size(r_size);
    assign nxt_new  = orsb_pkg::advance(r_new, size);
    assign nxt_idx  = orsb_pkg::advance(r_idx, size);
    assign accept   = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == orsb_pkg::REG_SIZE_IN_USE);

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == orsb_pkg::REG_SIZE_IN_USE)
                         ? orsb_pkg::PDATA_W'(r_size) : '0;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            orsb_pkg::ST_IDLE: begin
                if (accept && i_in.op == orsb_pkg::OP_SNAP && r_fill != '0) begin
                    n_state = orsb_pkg::ST_SNAP;
                end
            end
            orsb_pkg::ST_SNAP: begin
                if (out_free && r_left == orsb_pkg::CNT_W'(1)) begin
                    n_state = orsb_pkg::ST_IDLE;
                end
            end
            default: n_state = orsb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        n_fill     = r_fill;
        n_old      = r_old;
        n_new      = r_new;
        n_size     = r_size;
        n_idx      = r_idx;
        n_left     = r_left;
        out_load   = 1'b0;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_old;
        case (r_state)
            orsb_pkg::ST_IDLE: begin
                o_in_ready = (i_in.op == orsb_pkg::OP_PUSH) || out_free;
                if (accept && i_in.op == orsb_pkg::OP_PUSH) begin
                    ram_we = 1'b1;
                    if (r_fill == '0) begin
                        ram_waddr = '0;
                        n_old     = '0;
                        n_new     = '0;
                        n_fill    = orsb_pkg::CNT_W'(1);
                    end else begin
                        ram_waddr = nxt_new;
                        n_new     = nxt_new;
                        if (r_fill >= size) begin
                            n_old = orsb_pkg::advance(r_old, size);
                        end else begin
                            n_fill = r_fill + orsb_pkg::CNT_W'(1);
                        end
                    end
                end else if (accept) begin
                    if (r_fill == '0) begin
                        out_load = 1'b1;
                        n_out    = '{value: '0, status: orsb_pkg::STATUS_EMPTY, last: 1'b1};
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_old;
                        n_idx     = r_old;
                        n_left    = r_fill;
                    end
                end
            end
            orsb_pkg::ST_SNAP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{value: ram_rdata, status: orsb_pkg::STATUS_WORD,
                                 last: (r_left == orsb_pkg::CNT_W'(1))};
                    if (r_left != orsb_pkg::CNT_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = nxt_idx;
                        n_idx     = nxt_idx;
                        n_left    = r_left - orsb_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        if (cfg_wr) begin
            n_size = pwdata[orsb_pkg::SIZE_W-1:0];
            n_fill = '0;
            n_old  = '0;
            n_new  = '0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orsb_pkg::ST_IDLE;
            r_fill      <= '0;
            r_old       <= '0;
            r_new       <= '0;
            r_size      <= orsb_pkg::SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_old       <= n_old;
            r_new       <= n_new;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_out  <= n_out;
    end

    orsb_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### hw/rtl/orsb_ram.sv
// Single-port-write, registered-read slot memory of the ring buffer.
`timescale 1ns / 1ps
`default_nettype none

module orsb_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [orsb_pkg::IDX_W-1:0]    i_waddr,
    input  wire logic [orsb_pkg::WORD_W-1:0]   i_wdata,
    input  wire logic                          i_re,
    input  wire logic [orsb_pkg::IDX_W-1:0]    i_raddr,
    output logic      [orsb_pkg::WORD_W-1:0]   o_rdata
);

    logic [orsb_pkg::WORD_W-1:0] r_mem [orsb_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### dv/overwrite_ring_snapshot_buffer_test.sv
// Self-checking testbench for the overwrite ring snapshot buffer: directed cases, then random traffic.
`timescale 1ns / 1ps

module overwrite_ring_snapshot_buffer_test;
    import orsb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REG_STRIDE    = 4;
    localparam logic [PADDR_W-1:0] SIZE_ADDR   =
        PADDR_W'(int'(REG_SIZE_IN_USE) * REG_STRIDE);
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = SIZE_ADDR + PADDR_W'(REG_STRIDE);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in in_beat;
    logic out_valid;
    logic out_ready;
    t_out out_beat;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0] oldest_slot;
    logic [IDX_W-1:0] newest_slot;
    logic [CNT_W-1:0] held_words;
    logic [SIZE_W-1:0] size_setting;
    t_out due_beats [$];
    t_out want_beat;

    int mismatches = 0;
    int cycle_count = 0;
    bit in_up;
    bit gaps_on;
    bit stalls_on;

    overwrite_ring_snapshot_buffer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("overwrite_ring_snapshot_buffer_test: done, errors");
            $finish;
        end
    end

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx, input int span);
        return (int'(idx) + 1 >= span) ? '0 : idx + 1'b1;
    endfunction

    task automatic ring_accept(input t_in item);
        int span;
        int n;
        logic [IDX_W-1:0] idx;
        t_out beat;
        span = int'(size_setting);
        if (span < 1) begin
            span = 1;
        end
        if (span > DEPTH) begin
            span = DEPTH;
        end
        if (item.op == OP_PUSH) begin
            if (held_words == '0) begin
                oldest_slot = '0;
                newest_slot = '0;
                ring_words[0] = item.push_value;
                held_words = CNT_W'(1);
            end else begin
                newest_slot = next_slot(newest_slot, span);
                ring_words[newest_slot] = item.push_value;
                if (int'(held_words) >= span) begin
                    oldest_slot = next_slot(oldest_slot, span);
                end else begin
                    held_words = held_words + 1'b1;
                end
            end
        end else if (held_words == '0) begin
            beat.value = '0;
            beat.status = STATUS_EMPTY;
            beat.last = 1'b1;
            due_beats.push_back(beat);
        end else begin
            n = (int'(held_words) > span) ? span : int'(held_words);
            idx = oldest_slot;
            for (int k = 0; k < n; k++) begin
                beat.value = ring_words[idx];
                beat.status = STATUS_WORD;
                beat.last = (k == n - 1);
                due_beats.push_back(beat);
                idx = next_slot(idx, span);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, actual %h/%b/%b",
                         $time, out_beat.value, out_beat.status, out_beat.last);
                mismatches++;
            end else begin
                want_beat = due_beats.pop_front();
                if (out_beat.value !== want_beat.value) begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want_beat.value, out_beat.value);
                    mismatches++;
                end
                if (out_beat.status !== want_beat.status) begin
                    $display("%0t: status mismatch, expected %b, actual %b",
                             $time, want_beat.status, out_beat.status);
                    mismatches++;
                end
                if (out_beat.last !== want_beat.last) begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want_beat.last, out_beat.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input t_in item);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            if (in_up) begin
                in_valid <= 1'b0;
                in_up = 1'b0;
            end
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_up = 1'b1;
        in_beat <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        ring_accept(item);
    endtask

    task automatic push_word(input logic [WORD_W-1:0] word);
        t_in item;
        item.op = OP_PUSH;
        item.push_value = word;
        send_item(item);
    endtask

    task automatic request_snapshot();
        t_in item;
        item.op = OP_SNAP;
        item.push_value = $urandom;
        send_item(item);
    endtask

    // Drop the input, wait until every expected output beat has been seen, then let the ring settle.
    task automatic wait_idle();
        if (in_up) begin
            in_valid <= 1'b0;
            in_up = 1'b0;
        end
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == SIZE_ADDR) begin
            size_setting = data[SIZE_W-1:0];
            oldest_slot = '0;
            newest_slot = '0;
            held_words = '0;
        end
    endtask

    task automatic run_mix(input int count, input int snap_pct);
        t_in item;
        for (int k = 0; k < count; k++) begin
            item.op = ($urandom_range(1, 100) <= snap_pct) ? OP_SNAP : OP_PUSH;
            case ($urandom_range(0, 9))
                0: item.push_value = '0;
                1: item.push_value = '1;
                default: item.push_value = $urandom;
            endcase
            send_item(item);
        end
    endtask

    task automatic test_empty_after_reset();
        request_snapshot();
        push_word('1);
        request_snapshot();
    endtask

    task automatic test_word_extremes();
        push_word('0);
        push_word(32'hAAAA_AAAA);
        push_word(32'h5555_5555);
        request_snapshot();
    endtask

    task automatic test_unmapped_register();
        wait_idle();
        write_reg(UNUSED_ADDR, PDATA_W'(1));
        request_snapshot();
    endtask

    task automatic test_overwrite_oldest();
        wait_idle();
        write_reg(SIZE_ADDR, PDATA_W'(3));
        request_snapshot();
        repeat (5) push_word($urandom);
        request_snapshot();
    endtask

    task automatic test_size_clamping();
        wait_idle();
        write_reg(SIZE_ADDR, PDATA_W'(0));
        push_word($urandom);
        push_word($urandom);
        request_snapshot();
        wait_idle();
        write_reg(SIZE_ADDR, PDATA_W'(127));
        push_word($urandom);
        request_snapshot();
    endtask

    task automatic test_drain_pause();
        push_word($urandom);
        request_snapshot();
        wait_idle();
        push_word($urandom);
        request_snapshot();
    endtask

    task automatic test_random_traffic();
        int sizes [7] = '{2, 5, 1, 0, 64, 127, 0};
        int counts [7] = '{25, 25, 25, 25, 30, 80, 30};
        int snap_pcts [7] = '{25, 25, 25, 25, 20, 5, 20};
        logic [PDATA_W-1:0] data;
        sizes[6] = $urandom_range(1, DEPTH);
        for (int p = 0; p < 7; p++) begin
            wait_idle();
            if (p == 6) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            data = $urandom;
            data[SIZE_W-1:0] = SIZE_W'(sizes[p]);
            write_reg(SIZE_ADDR, data);
            run_mix(counts[p], snap_pcts[p]);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_beat <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_up = 1'b0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        size_setting = SIZE_RESET;
        oldest_slot = '0;
        newest_slot = '0;
        held_words = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_after_reset();
        test_word_extremes();
        test_unmapped_register();
        test_overwrite_oldest();
        test_size_clamping();
        test_drain_pause();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("overwrite_ring_snapshot_buffer_test: done, clean");
        end else begin
            $display("overwrite_ring_snapshot_buffer_test: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/orsb_pkg.sv
hw/rtl/orsb_ram.sv
hw/rtl/overwrite_ring_snapshot_buffer.sv
dv/overwrite_ring_snapshot_buffer_test.sv
